### rtl/rref_pkg.sv
// ----------------------------------------------------------------------------
// rref_pkg
// shared types, verdict codes and register indexes for the RIPv2 route
// entry filter
// ----------------------------------------------------------------------------
package rref_pkg;

  // verdict codes
  localparam logic [3:0] VERDICT_ACCEPT       = 4'd0;
  localparam logic [3:0] VERDICT_FAMILY       = 4'd1;
  localparam logic [3:0] VERDICT_METRIC       = 4'd2;
  localparam logic [3:0] VERDICT_PREFIX       = 4'd3;
  localparam logic [3:0] VERDICT_DFLT_SKIPPED = 4'd4;
  localparam logic [3:0] VERDICT_MULTICAST    = 4'd5;
  localparam logic [3:0] VERDICT_LOOPBACK     = 4'd6;
  localparam logic [3:0] VERDICT_EXPERIMENTAL = 4'd7;
  localparam logic [3:0] VERDICT_NET0         = 4'd8;
  localparam logic [3:0] VERDICT_DEFAULT      = 4'd9;
  localparam logic [3:0] VERDICT_OWN_ADDR     = 4'd10;
  localparam logic [3:0] VERDICT_OWN_BCAST    = 4'd11;
  localparam logic [3:0] VERDICT_NH_SELF      = 4'd12;

  // configuration register indexes
  localparam logic [2:0] REG_LINK_COST       = 3'd0;
  localparam logic [2:0] REG_ACCEPT_DEFAULT  = 3'd1;
  localparam logic [2:0] REG_PORT_ADDRESS    = 3'd2;
  localparam logic [2:0] REG_PORT_PREFIX_LEN = 3'd3;
  localparam logic [2:0] REG_BCAST_ADDRESS   = 3'd4;
  localparam logic [2:0] REG_BCAST_VALID     = 3'd5;

  // protocol constants
  localparam logic [15:0] AF_IPV4         = 16'd2;
  localparam logic [15:0] METRIC_INFINITY = 16'd16;
  localparam logic [4:0]  METRIC_INF5     = 5'd16;
  localparam logic [5:0]  PREFIX_MAX      = 6'd32;

  typedef struct packed {
    logic [31:0] source_address;
    logic [15:0] address_family;
    logic [15:0] route_tag_in;
    logic [31:0] dest_address;
    logic [5:0]  prefix_length;
    logic [31:0] next_hop_in;
    logic [15:0] metric_in;
    logic        last_entry;
  } in_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [31:0] route_network;
    logic [5:0]  route_prefix_len;
    logic [31:0] next_hop_out;
    logic [4:0]  metric_out;
    logic [15:0] route_tag_out;
    logic        last_out;
  } out_t;

  // port configuration seen by the stages
  typedef struct packed {
    logic [4:0]  link_cost;
    logic        accept_default;
    logic [31:0] port_address;
    logic [5:0]  port_prefix_len;
    logic [31:0] broadcast_address;
    logic        broadcast_valid;
  } cfg_t;

  // stage payload after the entry checks and prefix fill-in
  typedef struct packed {
    logic [3:0]  verdict;
    logic [31:0] net;
    logic [5:0]  len;
    logic [31:0] src;
    logic [31:0] nh;
    logic [4:0]  met;
    logic [15:0] tag;
    logic        last;
  } s1_t;

  // prefix length to netmask, lengths of 32 and above give all ones
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len >= PREFIX_MAX) m = '1;
    else m = ~(32'hFFFF_FFFF >> len);
    return m;
  endfunction

endpackage

### rtl/rref_check.sv
// ----------------------------------------------------------------------------
// rref_check
// first stage: family, metric and prefix checks, classful fill-in, masking
// ----------------------------------------------------------------------------
module rref_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_in,
  input  rref_pkg::in_t       data_in,
  output logic                vld_r,
  output rref_pkg::s1_t       data_r
);

  rref_pkg::s1_t data_nxt;
  logic [5:0]    len_fill;

  // classful prefix for a zero length with a nonzero address
  always_comb begin
    len_fill = data_in.prefix_length;
    if (data_in.prefix_length == 6'd0 && data_in.dest_address != 32'd0) begin
      if (!data_in.dest_address[31])                     len_fill = 6'd8;
      else if (data_in.dest_address[31:30] == 2'b10)     len_fill = 6'd16;
      else if (data_in.dest_address[31:29] == 3'b110)    len_fill = 6'd24;
      else                                               len_fill = 6'd32;
    end
  end

  // early verdict and cleaned fields
  always_comb begin
    data_nxt.verdict = rref_pkg::VERDICT_ACCEPT;
    if (data_in.address_family != rref_pkg::AF_IPV4)
      data_nxt.verdict = rref_pkg::VERDICT_FAMILY;
    else if (data_in.metric_in > rref_pkg::METRIC_INFINITY)
      data_nxt.verdict = rref_pkg::VERDICT_METRIC;
    else if (data_in.prefix_length > rref_pkg::PREFIX_MAX)
      data_nxt.verdict = rref_pkg::VERDICT_PREFIX;
    data_nxt.net  = data_in.dest_address & rref_pkg::len_mask(len_fill);
    data_nxt.len  = len_fill;
    data_nxt.src  = data_in.source_address;
    data_nxt.nh   = data_in.next_hop_in;
    data_nxt.met  = data_in.metric_in[4:0];
    data_nxt.tag  = data_in.route_tag_in;
    data_nxt.last = data_in.last_entry;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/rref_screen.sv
// ----------------------------------------------------------------------------
// rref_screen
// second stage: default route, address class and own address checks
// ----------------------------------------------------------------------------
module rref_screen (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  rref_pkg::cfg_t      cfg,
  input  logic                vld_in,
  input  rref_pkg::s1_t       data_in,
  output logic                vld_r,
  output rref_pkg::s1_t       data_r
);

  rref_pkg::s1_t data_nxt;
  logic [7:0]    top;

  assign top = data_in.net[31:24];

  // first failing check decides
  always_comb begin
    data_nxt = data_in;
    if (data_in.verdict == rref_pkg::VERDICT_ACCEPT) begin
      if (data_in.len == 6'd0 && data_in.net == 32'd0 && !cfg.accept_default)
        data_nxt.verdict = rref_pkg::VERDICT_DFLT_SKIPPED;
      else if (top[7:4] == 4'hE)
        data_nxt.verdict = rref_pkg::VERDICT_MULTICAST;
      else if (top == 8'h7F)
        data_nxt.verdict = rref_pkg::VERDICT_LOOPBACK;
      else if (top[7:4] == 4'hF)
        data_nxt.verdict = rref_pkg::VERDICT_EXPERIMENTAL;
      else if (top == 8'h00 && data_in.len != 6'd0)
        data_nxt.verdict = rref_pkg::VERDICT_NET0;
      else if (top == 8'h00 && !cfg.accept_default)
        data_nxt.verdict = rref_pkg::VERDICT_DEFAULT;
      else if (data_in.len == rref_pkg::PREFIX_MAX &&
               data_in.net == cfg.port_address)
        data_nxt.verdict = rref_pkg::VERDICT_OWN_ADDR;
      else if (data_in.len == rref_pkg::PREFIX_MAX && cfg.broadcast_valid &&
               data_in.net == cfg.broadcast_address)
        data_nxt.verdict = rref_pkg::VERDICT_OWN_BCAST;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/rref_resolve.sv
// ----------------------------------------------------------------------------
// rref_resolve
// third stage: next hop resolution, metric update and result formatting
// ----------------------------------------------------------------------------
module rref_resolve (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  rref_pkg::cfg_t      cfg,
  input  logic                vld_in,
  input  rref_pkg::s1_t       data_in,
  output logic                vld_r,
  output rref_pkg::out_t      data_r
);

  rref_pkg::out_t data_nxt;
  logic [5:0]     pl;
  logic [31:0]    pmask;
  logic [31:0]    nh;
  logic           nh_self;
  logic [5:0]     met_sum;
  logic [4:0]     met;
  logic [3:0]     verdict;

  // port prefix clamped to 32
  assign pl    = (cfg.port_prefix_len > rref_pkg::PREFIX_MAX) ? rref_pkg::PREFIX_MAX
                                                              : cfg.port_prefix_len;
  assign pmask = rref_pkg::len_mask(pl);

  // next hop: zero or off-subnet becomes the sender, the own port address flags NH_SELF
  always_comb begin
    nh      = data_in.nh;
    nh_self = 1'b0;
    if (data_in.nh == 32'd0) begin
      nh = data_in.src;
    end else if (data_in.nh == cfg.port_address) begin
      nh_self = 1'b1;
    end else if ((data_in.nh & pmask) != (cfg.port_address & pmask)) begin
      nh = data_in.src;
    end
  end

  // metric plus link cost, saturated
  assign met_sum = {1'b0, data_in.met} + {1'b0, cfg.link_cost};
  assign met     = (met_sum > {1'b0, rref_pkg::METRIC_INF5}) ? rref_pkg::METRIC_INF5
                                                             : met_sum[4:0];

  assign verdict = (data_in.verdict == rref_pkg::VERDICT_ACCEPT && nh_self)
                   ? rref_pkg::VERDICT_NH_SELF : data_in.verdict;

  // rejected entries carry zero route fields
  always_comb begin
    data_nxt          = '0;
    data_nxt.verdict  = verdict;
    data_nxt.last_out = data_in.last;
    if (verdict == rref_pkg::VERDICT_ACCEPT) begin
      data_nxt.route_network    = data_in.net;
      data_nxt.route_prefix_len = data_in.len;
      data_nxt.next_hop_out     = nh;
      data_nxt.metric_out       = met;
      data_nxt.route_tag_out    = data_in.tag;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/rip_route_entry_filter.sv
// Checks one RIPv2 IPv4 route entry per cycle while in_stall is low and
// returns a verdict code plus, for accepted entries, the masked network,
// final prefix length, resolved next hop and updated metric. There are three
// register stages (entry checks, address screening, next hop and metric). An
// entry's result is presented once the last stage register loads it and is
// taken on an edge where out_stall is low. A new entry can be taken every
// cycle while in_stall is low. Each stage loads whenever it is empty or its
// contents move on, so bubbles close up under output stall and in_stall
// rises only when all three stages are full and the output is stalled.
// Configuration registers are written through the cfg port, which is always
// ready. A write takes effect at once, including on entries still in the
// pipeline, so write only while the pipeline is empty.
// ----------------------------------------------------------------------------
// rip_route_entry_filter
// top level: configuration registers and pipeline flow control
// ----------------------------------------------------------------------------
module rip_route_entry_filter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rref_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rref_pkg::out_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  rref_pkg::cfg_t cfg_r;
  rref_pkg::s1_t  s1_data, s2_data;
  logic           s1_vld, s2_vld;
  logic           en1, en2, en3;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.link_cost         <= 5'd1;
      cfg_r.accept_default    <= 1'b1;
      cfg_r.port_address      <= 32'd0;
      cfg_r.port_prefix_len   <= 6'd24;
      cfg_r.broadcast_address <= 32'd0;
      cfg_r.broadcast_valid   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rref_pkg::REG_LINK_COST:       cfg_r.link_cost         <= cfg_data[4:0];
        rref_pkg::REG_ACCEPT_DEFAULT:  cfg_r.accept_default    <= cfg_data[0];
        rref_pkg::REG_PORT_ADDRESS:    cfg_r.port_address      <= cfg_data;
        rref_pkg::REG_PORT_PREFIX_LEN: cfg_r.port_prefix_len   <= cfg_data[5:0];
        rref_pkg::REG_BCAST_ADDRESS:   cfg_r.broadcast_address <= cfg_data;
        rref_pkg::REG_BCAST_VALID:     cfg_r.broadcast_valid   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage load enables, a stage loads when empty or draining
  assign en3      = !out_valid || !out_stall;
  assign en2      = !s2_vld || en3;
  assign en1      = !s1_vld || en2;
  assign in_stall = !en1;

  rref_check u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en1),
    .vld_in  (in_valid),
    .data_in (in_data),
    .vld_r   (s1_vld),
    .data_r  (s1_data)
  );

  rref_screen u_screen (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en2),
    .cfg     (cfg_r),
    .vld_in  (s1_vld),
    .data_in (s1_data),
    .vld_r   (s2_vld),
    .data_r  (s2_data)
  );

  rref_resolve u_resolve (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en3),
    .cfg     (cfg_r),
    .vld_in  (s2_vld),
    .data_in (s2_data),
    .vld_r   (out_valid),
    .data_r  (out_data)
  );

endmodule

### rtl/rref_checker.sv
// ----------------------------------------------------------------------------
// rref_checker
// port-level assertions for the route entry filter, bound to the top level
// ----------------------------------------------------------------------------
module rref_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_stall,
  input  logic             out_valid,
  input  logic             out_stall,
  input  rref_pkg::out_t   out_data
);

  // a stalled transaction stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped under stall");

  // a stalled transaction keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed under stall");

  // rejected entries carry zero route fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict != rref_pkg::VERDICT_ACCEPT |->
      out_data.route_network == 32'd0 && out_data.next_hop_out == 32'd0 &&
      out_data.metric_out == 5'd0 && out_data.route_prefix_len == 6'd0 &&
      out_data.route_tag_out == 16'd0)
    else $error("rejected entry with nonzero route fields");

  // accepted routes are in range
  a_accept_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict == rref_pkg::VERDICT_ACCEPT |->
      out_data.metric_out <= rref_pkg::METRIC_INF5 &&
      out_data.route_prefix_len <= rref_pkg::PREFIX_MAX)
    else $error("accepted route out of range");

  // the input only stalls behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

endmodule

bind rip_route_entry_filter rref_checker u_rref_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
